// ===== design/query_param_stripper_core_defines.svh =====
// Assertion macros used by the query parameter stripper core.
`ifndef QUERY_PARAM_STRIPPER_CORE_DEFINES_SVH
`define QUERY_PARAM_STRIPPER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qps_pkg.sv =====
// Package with the types, character constants and prefix table of the query stripper.
`default_nettype none

package qps_pkg;

    localparam int OUT_LEN_MAX = 65535;
    localparam logic [15:0] LIMIT_CAP = (OUT_LEN_MAX < 65535) ? 16'(OUT_LEN_MAX) : 16'hFFFF;

    localparam int PREFIX_LEN = 7;
    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_LEN - 1);
    localparam logic [2:0] PREFIX_END = 3'(PREFIX_LEN);

    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_AMP = 8'h26;

    localparam logic ADDR_OUT_LIMIT = 1'b0;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        MODE_MATCH = 3'b001,
        MODE_KEEP  = 3'b010,
        MODE_DROP  = 3'b100
    } mode_t;

    typedef struct packed {
        logic        has_sep;
        logic [7:0]  sep_byte;
        logic [2:0]  pfx_cnt;
        logic [7:0]  chr;
        logic [3:0]  n_send;
        logic        has_status;
        logic [15:0] stat_len;
        logic        stat_ovf;
    } burst_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h66;
            3'd1: ch = 8'h69;
            3'd2: ch = 8'h65;
            3'd3: ch = 8'h6C;
            3'd4: ch = 8'h64;
            3'd5: ch = 8'h73;
            3'd6: ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/query_param_stripper_core.sv =====
// Top level of the query parameter stripper: decoder, burst register and output register.
//
// The input channel takes one query character a word, with is_last on the final one.
// Each input word is decoded in the cycle it is accepted and leaves a burst of zero to
// nine result words: an optional separator, a replayed part of the dropped prefix, the
// character itself and, after the final character, one status word with the length.
// The first result of a burst passes from the burst register into the output register.
// The output register sends one word per cycle unless the receiver stalls, so an input
// word with n results holds the burst register until all n are sent; one with none does not.
// A new input word is taken in the same cycle the burst register sends its last word.
// When the receiver stalls, the output word holds and the burst register waits; once
// it is full the input side stalls too. No word is lost or repeated.
// The APB port holds out_limit at address 0; write it only between words.
// Reset clears all query state and sets out_limit to 65535; no clearing pass is needed.
`default_nettype none
`include "query_param_stripper_core_defines.svh"

module query_param_stripper_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic      [7:0]  out_byte,
    output logic      [15:0] total_length,
    output logic             overflow,
    output logic             last_result
);
    import qps_pkg::*;

    logic [15:0] out_limit_reg;
    logic        seen_first_reg;
    logic        leading_q_reg;
    logic        any_kept_reg;
    logic [2:0]  pm_reg;
    mode_t       mode_reg;
    logic [15:0] emitted_reg;
    logic        ovf_reg;

    burst_t      burst_reg;
    burst_t      burst_next;
    logic        burst_valid_reg;
    logic [3:0]  idx_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] total_length_reg;
    logic        overflow_reg;
    logic        last_result_reg;

    logic        first_q;
    logic        is_amp;
    logic        match_hit;
    logic        main_sk;
    logic        last_sk;
    logic        sk;
    logic [2:0]  sk_pm;
    logic        has_char;
    mode_t       mode1;
    logic [2:0]  pm1;
    logic        has_sep;
    logic [3:0]  n_req;
    logic [15:0] limit;
    logic [15:0] avail;
    logic [3:0]  n_send;
    logic        ovf1;
    logic [15:0] emitted1;
    logic        any_kept1;
    logic        load_burst;

    logic        cfg_write;
    logic        in_fire;
    logic        adv;
    logic [3:0]  total;
    logic [3:0]  j;
    logic        el_last;
    logic        el_kind;
    logic [7:0]  el_byte;
    logic [15:0] el_len;
    logic        el_ovf;
    logic        burst_done;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_OUT_LIMIT) ? {16'h0000, out_limit_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= 16'hFFFF;
        end
        else if (cfg_write && (paddr[2] == ADDR_OUT_LIMIT))
        begin
            out_limit_reg <= pwdata[15:0];
        end
    end

    assign limit = (out_limit_reg < LIMIT_CAP) ? out_limit_reg : LIMIT_CAP;

    always_comb
    begin
        first_q = !seen_first_reg && (data_byte == CHAR_QUESTION);
        is_amp = (data_byte == CHAR_AMP);
        match_hit = (pm_reg != PREFIX_END) && (data_byte == prefix_char(pm_reg));
        main_sk = 1'b0;
        has_char = 1'b0;
        mode1 = mode_reg;
        pm1 = pm_reg;
        if (!first_q)
        begin
            if (is_amp)
            begin
                main_sk = (mode_reg == MODE_MATCH) && (pm_reg != 3'd0);
                mode1 = MODE_MATCH;
                pm1 = 3'd0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_MATCH:
                    begin
                        if (match_hit)
                        begin
                            if (pm_reg == PREFIX_LAST)
                            begin
                                mode1 = MODE_DROP;
                                pm1 = 3'd0;
                            end
                            else
                            begin
                                pm1 = pm_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            main_sk = 1'b1;
                            has_char = 1'b1;
                            mode1 = MODE_KEEP;
                            pm1 = 3'd0;
                        end
                    end
                    MODE_KEEP:
                    begin
                        has_char = 1'b1;
                    end
                    default:
                    begin
                        has_char = 1'b0;
                    end
                endcase
            end
        end

        last_sk = is_last && (mode1 == MODE_MATCH) && (pm1 != 3'd0);
        sk = main_sk || last_sk;
        if (main_sk)
        begin
            sk_pm = pm_reg;
        end
        else if (last_sk)
        begin
            sk_pm = pm1;
        end
        else
        begin
            sk_pm = 3'd0;
        end
        has_sep = sk && (any_kept_reg || leading_q_reg);
        n_req = {3'b000, has_sep} + {1'b0, sk_pm} + {3'b000, has_char};

        if (ovf_reg || (emitted_reg >= limit))
        begin
            avail = 16'h0000;
        end
        else
        begin
            avail = limit - emitted_reg;
        end
        if ({12'h000, n_req} > avail)
        begin
            n_send = avail[3:0];
            ovf1 = 1'b1;
        end
        else
        begin
            n_send = n_req;
            ovf1 = ovf_reg;
        end
        emitted1 = emitted_reg + {12'h000, n_send};
        any_kept1 = any_kept_reg || sk;
        load_burst = (n_send != 4'd0) || is_last;

        burst_next.has_sep = has_sep;
        burst_next.sep_byte = any_kept_reg ? CHAR_AMP : CHAR_QUESTION;
        burst_next.pfx_cnt = sk_pm;
        burst_next.chr = data_byte;
        burst_next.n_send = n_send;
        burst_next.has_status = is_last;
        burst_next.stat_len = (ovf1 || !any_kept1) ? 16'h0000 : emitted1;
        burst_next.stat_ovf = ovf1;
    end

    assign adv = !out_valid_reg || out_ready;
    assign total = burst_reg.n_send + {3'b000, burst_reg.has_status};
    assign el_last = (idx_reg == (total - 4'd1));
    assign burst_done = burst_valid_reg && adv && el_last;
    assign in_ready = !burst_valid_reg || burst_done;
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        j = idx_reg - {3'b000, burst_reg.has_sep};
        if (idx_reg < burst_reg.n_send)
        begin
            el_kind = KIND_CHAR;
            el_len = 16'h0000;
            el_ovf = 1'b0;
            if (burst_reg.has_sep && (idx_reg == 4'd0))
            begin
                el_byte = burst_reg.sep_byte;
            end
            else if (j < {1'b0, burst_reg.pfx_cnt})
            begin
                el_byte = prefix_char(j[2:0]);
            end
            else
            begin
                el_byte = burst_reg.chr;
            end
        end
        else
        begin
            el_kind = KIND_STATUS;
            el_byte = 8'h00;
            el_len = burst_reg.stat_len;
            el_ovf = burst_reg.stat_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg <= 1'b0;
            leading_q_reg <= 1'b0;
            any_kept_reg <= 1'b0;
            pm_reg <= 3'd0;
            mode_reg <= MODE_MATCH;
            emitted_reg <= 16'h0000;
            ovf_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (is_last)
            begin
                seen_first_reg <= 1'b0;
                leading_q_reg <= 1'b0;
                any_kept_reg <= 1'b0;
                pm_reg <= 3'd0;
                mode_reg <= MODE_MATCH;
                emitted_reg <= 16'h0000;
                ovf_reg <= 1'b0;
            end
            else
            begin
                seen_first_reg <= 1'b1;
                leading_q_reg <= leading_q_reg || first_q;
                any_kept_reg <= any_kept1;
                pm_reg <= pm1;
                mode_reg <= mode1;
                emitted_reg <= emitted1;
                ovf_reg <= ovf1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg <= 4'd0;
        end
        else if (in_fire)
        begin
            burst_valid_reg <= load_burst;
            idx_reg <= 4'd0;
        end
        else if (burst_valid_reg && adv)
        begin
            if (el_last)
            begin
                burst_valid_reg <= 1'b0;
                idx_reg <= 4'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            burst_reg <= burst_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= burst_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && burst_valid_reg)
        begin
            kind_reg <= el_kind;
            out_byte_reg <= el_byte;
            total_length_reg <= el_len;
            overflow_reg <= el_ovf;
            last_result_reg <= el_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign out_byte = out_byte_reg;
    assign total_length = total_length_reg;
    assign overflow = overflow_reg;
    assign last_result = last_result_reg;

    `QPS_ASSERT_SAME(a_burst_idx_in_range, burst_valid_reg, idx_reg < total, "Burst index past its end.")
    `QPS_ASSERT_SAME(a_status_is_last, out_valid_reg && (kind_reg == KIND_STATUS), last_result_reg, "Status word not marked last.")
    `QPS_ASSERT_SAME(a_char_fields_zero, out_valid_reg && (kind_reg == KIND_CHAR), (total_length_reg == 16'h0000) && !overflow_reg, "Character word carries status fields.")
    `QPS_ASSERT_SAME(a_overflow_len_zero, out_valid_reg && overflow_reg, total_length_reg == 16'h0000, "Overflow status with nonzero length.")
    `QPS_ASSERT_NEXT(a_last_clears_query, in_fire && is_last, !seen_first_reg && (emitted_reg == 16'h0000) && !ovf_reg, "Query state not cleared after final word.")

endmodule

`default_nettype wire
